FILE: hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared helpers for concurrent assertions in the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check that is disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

FILE: hdl/psbr_pkg.sv
// ============================================================================
// psbr_pkg
// Shared types and constants for the pixel shadow and background refresh block.
// ============================================================================
package psbr_pkg;

    localparam int PIXELS    = 131072;
    localparam int ADDR_W    = $clog2(PIXELS);
    localparam int IDX_W     = 17;
    localparam int CNT_W     = 8;
    localparam int CH_W      = 8;
    localparam int MILLI_W   = 10;
    localparam int PROD_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    localparam logic [CH_W-1:0]    LABEL_BG     = 8'd0;
    localparam logic [CH_W-1:0]    LABEL_SHADOW = 8'd127;
    localparam logic [CH_W-1:0]    HUE_PERIOD   = 8'd180;
    localparam logic [MILLI_W-1:0] MILLI        = 10'd1000;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 8'd255;

    localparam logic [MILLI_W-1:0] ALPHA_RST    = 10'd800;
    localparam logic [MILLI_W-1:0] BETA_RST     = 10'd900;
    localparam logic [CH_W-1:0]    SAT_RST      = 8'd60;
    localparam logic [CH_W-1:0]    HUE_RST      = 8'd10;
    localparam logic [CNT_W-1:0]   DISSOLVE_RST = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 3'd0,
        CFG_BETA     = 3'd1,
        CFG_SAT      = 3'd2,
        CFG_HUE      = 3'd3,
        CFG_DISSOLVE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } t_cs_req;

endpackage

FILE: hdl/pixel_shadow_and_background_refresh.sv
// ============================================================================
// pixel_shadow_and_background_refresh
// HSV shadow classifier with a per-pixel dissolve counter that requests
// background refresh for pixels that stay background long enough.
// ============================================================================
// Channel   Direction  tdata                                  tuser
// s_axis    in         pixel, cur H/S/V, bg H/S/V             model_label
// m_axis    out        out_index                              shadow, replace
// cfg       in         write enable, index, data              -
//
// One pixel is accepted per cycle unless m_axis stalls or the clearing pass
// runs. Its result passes through three register stages, the counter read,
// the multiply stage and the output stage, whose register drives m_axis.
// After reset all 131072 counter entries are cleared one entry per cycle while
// s_axis_tready stays low; configuration writes are taken.
// A stall on m_axis backs up through the pipeline without loss or repeats.
// ============================================================================
`include "assert_macros.svh"

module pixel_shadow_and_background_refresh (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pixel_index, cur_hue, cur_sat, cur_val, bg_hue, bg_sat, bg_val
    input  logic [psbr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // model_label
    input  logic [psbr_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_index
    output logic [psbr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // shadow_flag, replace_background
    output logic [psbr_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [psbr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [psbr_pkg::CFG_W-1:0]           i_cfg_data
);
    import psbr_pkg::*;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers.
    logic [MILLI_W-1:0] r_alpha;
    logic [MILLI_W-1:0] r_beta;
    logic [CH_W-1:0]    r_sat_lim;
    logic [CH_W-1:0]    r_hue_lim;
    logic [CNT_W-1:0]   r_dis_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RST;
            r_beta    <= BETA_RST;
            r_sat_lim <= SAT_RST;
            r_hue_lim <= HUE_RST;
            r_dis_lim <= DISSOLVE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA:    r_alpha   <= i_cfg_data;
                CFG_BETA:     r_beta    <= i_cfg_data;
                CFG_SAT:      r_sat_lim <= i_cfg_data[CH_W-1:0];
                CFG_HUE:      r_hue_lim <= i_cfg_data[CH_W-1:0];
                CFG_DISSOLVE: r_dis_lim <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control.
    logic r_s1_vld, r_s2_vld, r_s3_vld;
    logic w_s1_rdy, w_s2_rdy, w_s3_rdy, w_s1_move, w_in_xfer, w_cs_busy;

    assign w_s3_rdy      = !r_s3_vld || m_axis_tready;
    assign w_s2_rdy      = !r_s2_vld || w_s3_rdy;
    assign w_s1_rdy      = !r_s1_vld || w_s2_rdy;
    assign w_s1_move     = r_s1_vld && w_s2_rdy;
    assign s_axis_tready = w_s1_rdy && !w_cs_busy;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Stage 1: fields registered while the counter is read.
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s1_bg, r_s1_sh;
    logic [CH_W-1:0]  r_s1_ch, r_s1_cs, r_s1_cv, r_s1_bh, r_s1_bs, r_s1_bv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_vld <= w_in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_idx <= s_axis_tdata[16:0];
            r_s1_ch  <= s_axis_tdata[24:17];
            r_s1_cs  <= s_axis_tdata[32:25];
            r_s1_cv  <= s_axis_tdata[40:33];
            r_s1_bh  <= s_axis_tdata[48:41];
            r_s1_bs  <= s_axis_tdata[56:49];
            r_s1_bv  <= s_axis_tdata[64:57];
            r_s1_bg  <= (s_axis_tuser == LABEL_BG);
            r_s1_sh  <= (s_axis_tuser == LABEL_SHADOW);
        end
    end

    t_cs_req          w_cs_req;
    logic [CNT_W-1:0] w_cnt_cur, w_cnt_new;

    assign w_cs_req.rd_en   = w_in_xfer;
    assign w_cs_req.rd_addr = s_axis_tdata[ADDR_W-1:0];
    assign w_cs_req.wr_en   = w_s1_move;
    assign w_cs_req.wr_addr = r_s1_idx[ADDR_W-1:0];
    assign w_cs_req.wr_data = w_cnt_new;

    psbr_count_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_cs_req),
        .o_rd_data (w_cnt_cur),
        .o_busy    (w_cs_busy)
    );

    logic [CH_W-1:0]   w_ch_red, w_bh_red, w_hue_d, w_sat_d;
    logic [PROD_W-1:0] w_prod_cur, w_prod_lo, w_prod_hi;

    always_comb begin
        if (r_s1_bg && (w_cnt_cur <= r_dis_lim)) begin
            w_cnt_new = (w_cnt_cur == CNT_MAX) ? w_cnt_cur : w_cnt_cur + 1'b1;
        end else begin
            w_cnt_new = (w_cnt_cur == '0) ? w_cnt_cur : w_cnt_cur - 1'b1;
        end
    end

    assign w_ch_red   = (r_s1_ch >= HUE_PERIOD) ? r_s1_ch - HUE_PERIOD : r_s1_ch;
    assign w_bh_red   = (r_s1_bh >= HUE_PERIOD) ? r_s1_bh - HUE_PERIOD : r_s1_bh;
    assign w_hue_d    = abs_diff(w_ch_red, w_bh_red);
    assign w_sat_d    = abs_diff(r_s1_cs, r_s1_bs);
    assign w_prod_cur = PROD_W'(r_s1_cv) * PROD_W'(MILLI);
    assign w_prod_lo  = PROD_W'(r_alpha) * PROD_W'(r_s1_bv);
    assign w_prod_hi  = PROD_W'(r_beta) * PROD_W'(r_s1_bv);

    // Stage 2: products and differences registered, then compared.
    logic [IDX_W-1:0]  r_s2_idx;
    logic              r_s2_sh, r_s2_rep, r_s2_bv_nz, r_s2_sat_ok;
    logic [CH_W-1:0]   r_s2_hue_d;
    logic [PROD_W-1:0] r_s2_prod_cur, r_s2_prod_lo, r_s2_prod_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_idx      <= r_s1_idx;
            r_s2_sh       <= r_s1_sh;
            r_s2_rep      <= (w_cnt_new > r_dis_lim);
            r_s2_bv_nz    <= (r_s1_bv != '0);
            r_s2_sat_ok   <= (w_sat_d <= r_sat_lim);
            r_s2_hue_d    <= w_hue_d;
            r_s2_prod_cur <= w_prod_cur;
            r_s2_prod_lo  <= w_prod_lo;
            r_s2_prod_hi  <= w_prod_hi;
        end
    end

    logic [CH_W-1:0] w_hue_w, w_hue_dist;
    logic            w_val_ok, w_hue_ok, w_shadow;

    assign w_hue_w    = HUE_PERIOD - r_s2_hue_d;
    assign w_hue_dist = (r_s2_hue_d < w_hue_w) ? r_s2_hue_d : w_hue_w;
    assign w_hue_ok   = (w_hue_dist <= r_hue_lim);
    assign w_val_ok   = r_s2_bv_nz && (r_s2_prod_cur >= r_s2_prod_lo)
                        && (r_s2_prod_cur <= r_s2_prod_hi);
    assign w_shadow   = (w_val_ok && r_s2_sat_ok && w_hue_ok) || r_s2_sh;

    // Stage 3: output register.
    logic [IDX_W-1:0] r_s3_idx;
    logic             r_s3_shadow, r_s3_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_s3_rdy) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && w_s3_rdy) begin
            r_s3_idx    <= r_s2_idx;
            r_s3_shadow <= w_shadow;
            r_s3_rep    <= r_s2_rep;
        end
    end

    assign m_axis_tvalid = r_s3_vld;
    assign m_axis_tdata  = {(OUT_DATA_W - IDX_W)'(0), r_s3_idx};
    assign m_axis_tuser  = {r_s3_rep, r_s3_shadow};

    `ASSERT_CLK(a_no_accept_in_clear, i_clk, i_rst_n, w_cs_busy |-> !s_axis_tready,
                "input ready during clearing pass")
    `ASSERT_CLK(a_s1_hold, i_clk, i_rst_n,
                (r_s1_vld && !w_s1_move) |=> (r_s1_vld && $stable(r_s1_idx)),
                "stage 1 item lost or changed while stalled")
    `ASSERT_CLK(a_cnt_step, i_clk, i_rst_n,
                w_s1_move |-> ((w_cnt_new == w_cnt_cur) || (w_cnt_new == w_cnt_cur + 1'b1)
                               || (w_cnt_new == w_cnt_cur - 1'b1)),
                "counter moved by more than one")
    `ASSERT_NEVER(a_no_write_in_clear, i_clk, i_rst_n, w_cs_busy && w_s1_move,
                  "counter update during clearing pass")

endmodule

FILE: hdl/psbr_count_store.sv
// ============================================================================
// psbr_count_store
// Per-pixel dissolve counter memory with a clearing pass after reset and
// forwarding of the most recent write to a read issued in the same cycle.
// ============================================================================
module psbr_count_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psbr_pkg::t_cs_req               i_req,
    output logic [psbr_pkg::CNT_W-1:0]      o_rd_data,
    output logic                            o_busy
);
    import psbr_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PIXELS - 1);

    logic [CNT_W-1:0]  r_mem [PIXELS];
    logic [CNT_W-1:0]  r_rd_q;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              r_wr_vld;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [CNT_W-1:0]  r_wr_data;

    assign n_clr_addr = r_clr_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q    <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
        if (i_req.wr_en) begin
            r_wr_addr <= i_req.wr_addr;
            r_wr_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_wr_vld   <= 1'b0;
        end else begin
            if (r_busy) begin
                r_clr_addr <= n_clr_addr;
                if (r_clr_addr == ADDR_LAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_req.wr_en) begin
                r_wr_vld <= 1'b1;
            end
        end
    end

    // Outside the clearing pass the write register mirrors the memory at its address,
    // so it may override the read data whenever the addresses match.
    assign o_rd_data = (r_wr_vld && (r_wr_addr == r_rd_addr)) ? r_wr_data : r_rd_q;
    assign o_busy    = r_busy;

endmodule

FILE: tb/psbr_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// psbr_result_checker
// Watches the pixel stream, the result stream and the register port. For
// every accepted pixel it works out the shadow and refresh flags from its own
// copy of the thresholds and the per-pixel dissolve levels. Each result
// transfer is then compared with the oldest outstanding prediction.
// ============================================================================
module psbr_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // pixel_index, cur_hue, cur_sat, cur_val, bg_hue, bg_sat, bg_val
    input  logic [psbr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // model_label
    input  logic [psbr_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_index
    input  logic [psbr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // shadow_flag, replace_background
    input  logic [psbr_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [psbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psbr_pkg::CFG_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import psbr_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             shadow;
        logic             refresh;
    } t_verdict;

    logic [MILLI_W-1:0] alpha_milli;
    logic [MILLI_W-1:0] beta_milli;
    logic [CH_W-1:0]    sat_limit;
    logic [CH_W-1:0]    hue_limit;
    logic [CNT_W-1:0]   dissolve_limit;
    logic [CNT_W-1:0]   dissolve_level [int];
    t_verdict           verdict_q [$];
    int                 mismatches = 0;

    function automatic int unsigned hue_gap(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b);
        int unsigned ra;
        int unsigned rb;
        int unsigned d;
        ra = a % HUE_PERIOD;
        rb = b % HUE_PERIOD;
        d  = (ra >= rb) ? ra - rb : rb - ra;
        return (d < HUE_PERIOD - d) ? d : HUE_PERIOD - d;
    endfunction

    function automatic t_verdict classify_pixel(input logic [IN_DATA_W-1:0] data,
                                                input logic [IN_USER_W-1:0] label);
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  cur_hue, cur_sat, cur_val, bg_hue, bg_sat, bg_val;
        logic [CNT_W-1:0] level;
        int               addr;
        int unsigned      scaled;
        int unsigned      sat_gap;
        logic             value_ok;
        t_verdict         v;
        index   = data[16:0];
        cur_hue = data[24:17];
        cur_sat = data[32:25];
        cur_val = data[40:33];
        bg_hue  = data[48:41];
        bg_sat  = data[56:49];
        bg_val  = data[64:57];
        addr    = int'(index) % PIXELS;
        level   = dissolve_level.exists(addr) ? dissolve_level[addr] : '0;
        if (label == LABEL_BG && level <= dissolve_limit) begin
            if (level != CNT_MAX) level = level + 1'b1;
        end else if (level != '0) begin
            level = level - 1'b1;
        end
        dissolve_level[addr] = level;
        scaled   = int'(cur_val) * int'(MILLI);
        value_ok = (bg_val != '0) && (scaled >= int'(alpha_milli) * int'(bg_val))
                   && (scaled <= int'(beta_milli) * int'(bg_val));
        sat_gap  = (cur_sat >= bg_sat) ? cur_sat - bg_sat : bg_sat - cur_sat;
        v.index   = index;
        v.refresh = level > dissolve_limit;
        v.shadow  = (value_ok && sat_gap <= sat_limit
                     && hue_gap(cur_hue, bg_hue) <= hue_limit)
                    || label == LABEL_SHADOW;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict seen;
        t_verdict want;
        if (!i_rst_n) begin
            alpha_milli    = ALPHA_RST;
            beta_milli     = BETA_RST;
            sat_limit      = SAT_RST;
            hue_limit      = HUE_RST;
            dissolve_limit = DISSOLVE_RST;
            dissolve_level.delete();
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ALPHA:    alpha_milli    = i_cfg_data[MILLI_W-1:0];
                    CFG_BETA:     beta_milli     = i_cfg_data[MILLI_W-1:0];
                    CFG_SAT:      sat_limit      = i_cfg_data[CH_W-1:0];
                    CFG_HUE:      hue_limit      = i_cfg_data[CH_W-1:0];
                    CFG_DISSOLVE: dissolve_limit = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                verdict_q.push_back(classify_pixel(s_axis_tdata, s_axis_tuser));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.index   = m_axis_tdata[IDX_W-1:0];
                seen.shadow  = m_axis_tuser[0];
                seen.refresh = m_axis_tuser[1];
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transfer with no pixel outstanding: index %0d",
                                 $realtime, seen.index);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (seen.index != want.index || seen.shadow != want.shadow
                        || seen.refresh != want.refresh) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: exp idx %0d sh %b rep %b got idx %0d sh %b rep %b",
                                     $realtime, want.index, want.shadow, want.refresh,
                                     seen.index, seen.shadow, seen.refresh);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= verdict_q.size();
    end

endmodule

FILE: tb/pixel_shadow_and_background_refresh_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// pixel_shadow_and_background_refresh_tb
// Drives directed and random pixels through the shadow classifier under
// several threshold settings and changing backpressure, and lets the checker
// compare every result transfer. Prints the verdict at the end of the run.
// ============================================================================
module pixel_shadow_and_background_refresh_tb;
    import psbr_pkg::*;

    localparam int STALL_LIMIT = 400000;
    localparam int HUE_SPAN    = HUE_PERIOD;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  label;
        logic [CH_W-1:0]  cur_hue;
        logic [CH_W-1:0]  cur_sat;
        logic [CH_W-1:0]  cur_val;
        logic [CH_W-1:0]  bg_hue;
        logic [CH_W-1:0]  bg_sat;
        logic [CH_W-1:0]  bg_val;
    } t_pixel;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;

    int fail_count;
    int pending;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int stall_cycles = 0;
    int cfg_alpha    = ALPHA_RST;
    int cfg_beta     = BETA_RST;
    int cfg_sat      = SAT_RST;
    int cfg_hue      = HUE_RST;

    pixel_shadow_and_background_refresh DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    psbr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic feed_pixel(input t_pixel px);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-65){1'b0}}, px.bg_val, px.bg_sat, px.bg_hue,
                          px.cur_val, px.cur_sat, px.cur_hue, px.index};
        s_axis_tuser  <= px.label;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_thresholds(input int alpha, input int beta, input int sat,
                                   input int hue, input int dis);
        cfg_alpha = alpha;
        cfg_beta  = beta;
        cfg_sat   = sat;
        cfg_hue   = hue;
        write_reg(CFG_ALPHA, alpha[CFG_W-1:0]);
        write_reg(CFG_BETA, beta[CFG_W-1:0]);
        write_reg(CFG_SAT, {2'($urandom_range(3)), sat[7:0]});
        write_reg(CFG_HUE, {2'($urandom_range(3)), hue[7:0]});
        write_reg(CFG_DISSOLVE, {2'($urandom_range(3)), dis[7:0]});
        i_cfg_we <= 1'b0;
    endtask

    // Most pixels sit near the shadow boundaries of the current thresholds and
    // land on a few hot indices so that the dissolve levels move far.
    function automatic t_pixel draw_pixel(input int hot_pct, input int hot_span,
                                          input int bg_pct);
        t_pixel px;
        int     pick;
        int     k;
        int     spread;
        int     base;
        pick = $urandom_range(99);
        if (pick < hot_pct) begin
            px.index = IDX_W'($urandom_range(hot_span - 1));
        end else if (pick < hot_pct + (100 - hot_pct) / 2) begin
            px.index = IDX_W'($urandom());
        end else begin
            px.index = IDX_W'(PIXELS - 1 - int'($urandom_range(3)));
        end
        pick = $urandom_range(99);
        if (pick < bg_pct) begin
            px.label = LABEL_BG;
        end else if (pick < bg_pct + (100 - bg_pct) / 4) begin
            px.label = LABEL_SHADOW;
        end else begin
            px.label = CH_W'($urandom());
        end
        if ($urandom_range(99) < 60) begin
            px.bg_val  = CH_W'($urandom_range(255, 1));
            k          = $urandom_range(cfg_beta + 20, (cfg_alpha > 20) ? cfg_alpha - 20 : 0);
            base       = (int'(px.bg_val) * k + 500) / 1000;
            px.cur_val = (base > 255) ? 8'd255 : CH_W'(base);
            px.bg_hue  = CH_W'($urandom());
            spread     = cfg_hue + 2;
            base       = int'(px.bg_hue) % HUE_SPAN + 3 * HUE_SPAN
                         + int'($urandom_range(2 * spread)) - spread;
            base       = base % HUE_SPAN;
            if (base < 256 - HUE_SPAN && $urandom_range(1) == 1) base += HUE_SPAN;
            px.cur_hue = CH_W'(base);
            px.bg_sat  = CH_W'($urandom());
            spread     = cfg_sat + 2;
            base       = int'(px.bg_sat) + int'($urandom_range(2 * spread)) - spread;
            px.cur_sat = (base < 0) ? 8'd0 : (base > 255) ? 8'd255 : CH_W'(base);
        end else begin
            px.cur_hue = CH_W'($urandom());
            px.cur_sat = CH_W'($urandom());
            px.cur_val = CH_W'($urandom());
            px.bg_hue  = CH_W'($urandom());
            px.bg_sat  = CH_W'($urandom());
            px.bg_val  = CH_W'($urandom());
        end
        return px;
    endfunction

    initial begin
        int alpha_pick;
        send_gap_pct = 31;
        recv_gap_pct = 64;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: ratio 0.8 to 0.9, saturation 60, hue 10, dissolve 20.
        feed_pixel('{17'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        feed_pixel('{IDX_W'(PIXELS - 1), LABEL_SHADOW, 8'd255, 8'd255, 8'd255,
                     8'd255, 8'd255, 8'd255});
        feed_pixel('{17'd7, LABEL_BG, 8'd175, 8'd100, 8'd200, 8'd5, 8'd40, 8'd250});
        feed_pixel('{17'd7, LABEL_BG, 8'd16, 8'd40, 8'd225, 8'd5, 8'd100, 8'd250});
        feed_pixel('{17'd7, LABEL_BG, 8'd10, 8'd40, 8'd226, 8'd5, 8'd100, 8'd250});
        feed_pixel('{17'd7, 8'd1, 8'd10, 8'd40, 8'd199, 8'd5, 8'd100, 8'd250});
        feed_pixel('{17'd7, LABEL_SHADOW, 8'd90, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
        feed_pixel('{17'd8, 8'd126, 8'd179, 8'd0, 8'd200, 8'd0, 8'd61, 8'd250});
        feed_pixel('{17'd8, 8'd128, 8'd200, 8'd60, 8'd200, 8'd20, 8'd0, 8'd250});
        feed_pixel('{17'd9, LABEL_BG, 8'd90, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        feed_pixel('{17'd9, LABEL_BG, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
        feed_pixel('{17'd10, LABEL_BG, 8'd250, 8'd128, 8'd128, 8'd70, 8'd128, 8'd160});
        feed_pixel('{IDX_W'(PIXELS - 1), LABEL_BG, 8'd170, 8'd255, 8'd255,
                     8'd255, 8'd255, 8'd255});
        feed_pixel('{17'h15555, 8'd64, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170});
        feed_pixel('{17'h0AAAA, 8'd191, 8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85});
        feed_pixel('{17'd7, LABEL_BG, 8'd0, 8'd255, 8'd255, 8'd179, 8'd255, 8'd255});
        feed_pixel('{17'd7, LABEL_BG, 8'd180, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        drain_results();

        load_thresholds(0, 1023, 255, 255, 0);
        repeat (40) feed_pixel(draw_pixel(85, 4, 60));
        drain_results();

        send_gap_pct = 64;
        recv_gap_pct = 31;
        load_thresholds(1000, 1000, 0, 0, 254);
        repeat (30) feed_pixel(draw_pixel(85, 4, 50));
        drain_results();

        alpha_pick = $urandom_range(900, 500);
        load_thresholds(alpha_pick, alpha_pick + $urandom_range(100), $urandom_range(255),
                        HUE_SPAN, 3);
        repeat (20) feed_pixel(draw_pixel(85, 2, 70));
        drain_results();
        repeat (20) feed_pixel(draw_pixel(85, 2, 70));
        drain_results();

        // Long background run on one pixel drives its level up to the top.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        load_thresholds(800, 1000, 60, 20, 255);
        repeat (290) feed_pixel(draw_pixel(98, 1, 98));
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/psbr_pkg.sv
hdl/psbr_count_store.sv
hdl/pixel_shadow_and_background_refresh.sv
tb/psbr_result_checker.sv
tb/pixel_shadow_and_background_refresh_tb.sv
